### hdl/dmpc_pkg.sv
`default_nettype none

package dmpc_pkg;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_DEBOUNCE_SAMPLES = 2'd0;
  localparam logic [1:0] REG_RELEASE_TICKS    = 2'd1;
  localparam logic [1:0] REG_PRESS_LEVEL      = 2'd2;

  localparam logic [7:0]  DEBOUNCE_SAMPLES_RST = 8'd10;
  localparam logic [15:0] RELEASE_TICKS_RST    = 16'd500;
  localparam logic        PRESS_LEVEL_RST      = 1'b0;

  localparam logic [7:0] COUNT_MAX = 8'hFF;

  typedef struct packed {
    logic [7:0]  debounce_samples;
    logic [15:0] release_ticks;
    logic        press_level;
  } dmpc_cfg_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] total;
  } dmpc_result_t;

endpackage

`default_nettype wire

### hdl/dmpc_core.sv
`default_nettype none

module dmpc_core #(
  parameter int TIMER_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  logic                  raw,
  input  dmpc_pkg::dmpc_cfg_t   cfg,
  output dmpc_pkg::dmpc_result_t result
);
  import dmpc_pkg::*;

  localparam int LoadW = (TIMER_BITS > 16) ? TIMER_BITS : 16;

  logic                  prev_sample;
  logic [7:0]            stable_run;
  logic                  clean_level;
  logic [7:0]            burst_presses;
  logic [TIMER_BITS-1:0] quiet_timer;
  logic                  timer_running;

  logic [7:0]            stable_run_next;
  logic                  accept;
  logic                  press_hit;
  logic                  released;
  logic [7:0]            presses_inc;
  logic [TIMER_BITS-1:0] timer_dec;
  logic                  expire;
  logic [LoadW-1:0]      ticks_ext;
  logic [LoadW-1:0]      timer_max;
  logic [LoadW-1:0]      load_wide;
  logic [TIMER_BITS-1:0] load;

  // A zero reload acts as one; a reload beyond the timer range saturates.
  assign ticks_ext = LoadW'(cfg.release_ticks);
  assign timer_max = LoadW'({TIMER_BITS{1'b1}});
  assign load_wide = (ticks_ext == '0) ? LoadW'(1) :
                     ((ticks_ext > timer_max) ? timer_max : ticks_ext);
  assign load      = load_wide[TIMER_BITS-1:0];

  always_comb begin
    if (raw == prev_sample) begin
      stable_run_next = (stable_run != COUNT_MAX) ? stable_run + 8'd1 : stable_run;
    end else begin
      stable_run_next = 8'd1;
    end
    accept      = (stable_run_next >= cfg.debounce_samples) && (raw != clean_level);
    press_hit   = accept && (raw == cfg.press_level);
    released    = accept && (raw != cfg.press_level);
    presses_inc = (press_hit && (burst_presses != COUNT_MAX)) ?
                  burst_presses + 8'd1 : burst_presses;
    timer_dec   = (quiet_timer != '0) ? quiet_timer - TIMER_BITS'(1) : quiet_timer;
    expire      = !released && timer_running && (timer_dec == '0);
  end

  // A press on the expiring tick is still part of the reported burst.
  assign result.hit   = expire;
  assign result.total = presses_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_sample   <= ~PRESS_LEVEL_RST;
      stable_run    <= 8'd0;
      clean_level   <= ~PRESS_LEVEL_RST;
      burst_presses <= 8'd0;
      quiet_timer   <= '0;
      timer_running <= 1'b0;
    end else if (step) begin
      prev_sample   <= raw;
      stable_run    <= stable_run_next;
      clean_level   <= accept ? raw : clean_level;
      burst_presses <= expire ? 8'd0 : presses_inc;
      if (released) begin
        quiet_timer   <= load;
        timer_running <= 1'b1;
      end else if (timer_running) begin
        quiet_timer   <= timer_dec;
        timer_running <= !expire;
      end
    end
  end

`ifndef SYNTHESIS
  a_hit_needs_timer: assert property (@(posedge clk) disable iff (rst)
    result.hit |-> timer_running)
    else $error("result raised while the quiet timer is stopped");

  a_running_nonzero: assert property (@(posedge clk) disable iff (rst)
    timer_running |-> (quiet_timer != '0))
    else $error("quiet timer running at zero");

  a_clear_after_report: assert property (@(posedge clk) disable iff (rst)
    (step && result.hit) |=> (burst_presses == 8'd0) && !timer_running)
    else $error("burst not cleared after report");

  a_level_holds: assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable(clean_level) && $stable(burst_presses))
    else $error("debounced state changed without a sample");
`endif

endmodule

`default_nettype wire

### hdl/debounced_multi_press_counter.sv
`default_nettype none

// Debounced multi-press counter for one button. Each input transfer carries one
// raw pin sample; a new level is taken once debounce_samples equal samples in a
// row have been seen. Each debounced press adds to a count that saturates at 255,
// and each debounced release (re)starts a quiet timer of release_ticks samples.
// When the timer runs out the count is sent as one output transfer and cleared.
// One sample is accepted every clock cycle while in_stall is low; it passes an
// input register and the state update, and its result, if any, is loaded into the
// output register. The output register lets input transfers continue while a
// result waits, and in_stall rises only when that result is still stalled and a
// second one would be needed. Configure the block only while it is idle.
module debounced_multi_press_counter #(
  parameter int TIMER_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        raw_level,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  press_total,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import dmpc_pkg::*;

  dmpc_cfg_t    cfg;
  dmpc_result_t result;

  logic s1_valid;
  logic s1_raw;
  logic step;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_samples <= DEBOUNCE_SAMPLES_RST;
      cfg.release_ticks    <= RELEASE_TICKS_RST;
      cfg.press_level      <= PRESS_LEVEL_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DEBOUNCE_SAMPLES: cfg.debounce_samples <= cfg_data[7:0];
        REG_RELEASE_TICKS:    cfg.release_ticks    <= cfg_data;
        REG_PRESS_LEVEL:      cfg.press_level      <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // The held sample is processed unless it makes a result while the output
  // register still holds a stalled one.
  assign step     = s1_valid && (!result.hit || !out_valid || !out_stall);
  assign in_stall = s1_valid && !step;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid <= 1'b1;
    end else if (step) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_raw <= raw_level;
    end
  end

  dmpc_core #(
    .TIMER_BITS(TIMER_BITS)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .raw    (s1_raw),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && result.hit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && result.hit) begin
      press_total <= result.total;
    end
  end

`ifndef SYNTHESIS
  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid && out_stall)
    else $error("input stalled without a blocked result");

  a_step_room: assert property (@(posedge clk) disable iff (rst)
    (step && result.hit) |=> out_valid && (press_total == $past(result.total)))
    else $error("result lost on its way to the output register");
`endif

endmodule

`default_nettype wire

### dv/press_report_monitor.sv
`timescale 1ns / 1ps

// Watches the sample, configuration and report channels of the press counter,
// keeps its own copy of the debounce and burst state, and checks every report
// against the oldest predicted press total.
module press_report_monitor #(
  parameter int TIMER_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        raw_level,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  press_total,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          mismatches,
  output int          reports_due,
  output int          reports_seen,
  output logic        timer_live
);
  import dmpc_pkg::*;

  localparam logic [63:0] QUIET_MAX = (64'd1 << TIMER_BITS) - 64'd1;

  logic [7:0]  need_run;
  logic [15:0] quiet_ticks;
  logic        active_level;

  logic        last_sample;
  logic [7:0]  run_len;
  logic        settled_level;
  logic [7:0]  press_tally;
  logic [63:0] quiet_count;
  logic        quiet_active;

  logic [7:0]  totals_due[$];
  int          errs = 0;
  int          seen = 0;

  task automatic clear_button();
    need_run      = DEBOUNCE_SAMPLES_RST;
    quiet_ticks   = RELEASE_TICKS_RST;
    active_level  = PRESS_LEVEL_RST;
    last_sample   = ~active_level;
    run_len       = 8'd0;
    settled_level = ~active_level;
    press_tally   = 8'd0;
    quiet_count   = 64'd0;
    quiet_active  = 1'b0;
    totals_due.delete();
  endtask

  task automatic take_sample(input logic level);
    logic        released;
    logic [63:0] load;
    released = 1'b0;
    if (level == last_sample) begin
      if (run_len != 8'hFF) run_len++;
    end else begin
      run_len = 8'd1;
    end
    last_sample = level;

    // A debounce setting of zero passes here on the first sample, like one.
    if (run_len >= need_run && level != settled_level) begin
      settled_level = level;
      if (level == active_level) begin
        if (press_tally != COUNT_MAX) press_tally++;
      end else begin
        released = 1'b1;
      end
    end

    if (released) begin
      load = (quiet_ticks == 16'd0) ? 64'd1 : {48'd0, quiet_ticks};
      if (load > QUIET_MAX) load = QUIET_MAX;
      quiet_count  = load;
      quiet_active = 1'b1;
    end else if (quiet_active) begin
      if (quiet_count != 64'd0) quiet_count--;
      if (quiet_count == 64'd0) begin
        totals_due.push_back(press_tally);
        press_tally  = 8'd0;
        quiet_active = 1'b0;
      end
    end
  endtask

  task automatic check_report(input logic [7:0] got);
    logic [7:0] want;
    seen++;
    if (totals_due.size() == 0) begin
      errs++;
      if (errs <= 10)
        $display("%0t: press report %0d carries %0d but none is pending", $realtime, seen, got);
    end else begin
      want = totals_due.pop_front();
      if (got !== want) begin
        errs++;
        if (errs <= 10)
          $display("%0t: press report %0d press_total expected %0d got %0d", $realtime, seen,
                   want, got);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_button();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_DEBOUNCE_SAMPLES: need_run     = cfg_data[7:0];
          REG_RELEASE_TICKS:    quiet_ticks  = cfg_data;
          REG_PRESS_LEVEL:      active_level = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) take_sample(raw_level);
      if (out_valid && !out_stall) check_report(press_total);
    end
    mismatches   <= errs;
    reports_due  <= totals_due.size();
    reports_seen <= seen;
    timer_live   <= quiet_active;
  end

endmodule

### dv/tb_debounced_multi_press_counter.sv
`timescale 1ns / 1ps

module tb_debounced_multi_press_counter;
  import dmpc_pkg::*;

  localparam int TIMER_BITS = 16;
  // Three presses and releases; the third press lands while the quiet timer runs.
  localparam logic [0:11] PRESS_SCRIPT = 12'b0111_1010_1111;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        raw_level = 1'b0;
  logic        out_stall = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [1:0]  cfg_index = REG_DEBOUNCE_SAMPLES;
  logic [15:0] cfg_data  = 16'd0;
  logic        in_stall;
  logic        out_valid;
  logic        cfg_ready;
  logic [7:0]  press_total;

  int   mismatches;
  int   reports_due;
  int   reports_seen;
  logic timer_live;

  int samples_sent   = 0;
  int burst_left     = 0;
  int settings_used  = 0;
  int stall_left     = 0;
  int stall_pct      = 0;

  debounced_multi_press_counter #(
    .TIMER_BITS(TIMER_BITS)
  ) DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .raw_level  (raw_level),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .press_total(press_total),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  press_report_monitor #(
    .TIMER_BITS(TIMER_BITS)
  ) u_reports (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .raw_level   (raw_level),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .press_total (press_total),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .reports_due (reports_due),
    .reports_seen(reports_seen),
    .timer_live  (timer_live)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // The report side stalls in segments, each with its own stall rate.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 30;
          2: stall_pct = 70;
          default: stall_pct = 100;
        endcase
        stall_left = (stall_pct == 100) ? $urandom_range(1, 12) : $urandom_range(10, 80);
      end
      stall_left--;
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  task automatic send_sample(input logic level);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_valid  <= 1'b1;
    raw_level <= level;
    do @(posedge clk); while (in_stall);
    burst_left--;
    samples_sent++;
  endtask

  task automatic write_field(input logic [1:0] index, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Upper data bits on the narrow registers are random and must be ignored.
  task automatic set_config(input logic [7:0] debounce, input logic [15:0] release_len,
                            input logic level);
    write_field(REG_DEBOUNCE_SAMPLES, {8'($urandom), debounce});
    write_field(REG_RELEASE_TICKS, release_len);
    write_field(REG_PRESS_LEVEL, {15'($urandom), level});
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  task automatic settle(input int guard_limit);
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    do begin
      @(posedge clk);
      guard++;
    end while (reports_due != 0 && guard < guard_limit);
    repeat (4) @(posedge clk);
  endtask

  // Mostly clean presses and releases with random hold times, some of them
  // bounces no longer than the debounce count, plus bursts of pure noise.
  task automatic random_phase(input int count, input logic [7:0] debounce,
                              input logic [15:0] release_len, input logic level,
                              input logic pause_midway);
    int   eff_deb;
    int   eff_rel;
    int   len;
    int   pick;
    int   stop_at;
    logic lvl;
    eff_deb = (debounce == 8'd0) ? 1 : debounce;
    eff_rel = (release_len == 16'd0) ? 1 : release_len;
    lvl     = level;
    stop_at = samples_sent + count;
    while (samples_sent < stop_at) begin
      if (pause_midway && samples_sent >= stop_at - count / 2) begin
        pause_midway = 1'b0;
        settle(5000);
      end
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        repeat ($urandom_range(1, 4)) send_sample(1'($urandom_range(0, 1)));
      end else begin
        lvl = ~lvl;
        if (pick < 30)
          len = $urandom_range(1, eff_deb);
        else if (lvl != level && pick >= 80)
          len = eff_deb + eff_rel + $urandom_range(0, 4);
        else
          len = eff_deb + $urandom_range(0, 3);
        repeat (len) send_sample(lvl);
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    set_config(8'd1, 16'd3, 1'b0);
    for (int i = 0; i < 12; i++) send_sample(PRESS_SCRIPT[i]);
    settle(5000);
    // The held level now counts as pressed, so letting go reports zero presses.
    set_config(8'd1, 16'd3, 1'b1);
    repeat (4) send_sample(1'b0);
    settle(5000);

    set_config(8'd0, 16'd0, 1'b1);
    random_phase(120, 8'd0, 16'd0, 1'b1, 1'b0);
    settle(5000);
    set_config(8'd3, 16'd20, 1'b0);
    random_phase(250, 8'd3, 16'd20, 1'b0, 1'b1);
    settle(5000);
    set_config(8'd2, 16'd7, 1'b1);
    random_phase(120, 8'd2, 16'd7, 1'b1, 1'b0);
    settle(5000);
    set_config(8'd255, 16'd1, 1'b0);
    random_phase(350, 8'd255, 16'd1, 1'b0, 1'b0);
    settle(5000);

    // Enough presses to saturate the count, then let the quiet timer run out.
    set_config(8'd1, 16'd200, 1'b0);
    repeat (260) begin
      send_sample(1'b0);
      send_sample(1'b1);
    end
    while (timer_live) send_sample(1'b1);

    settle(20000);
    $display("Sent %0d button samples under %0d register settings, checked %0d press reports.",
             samples_sent, settings_used, reports_seen);
    if (reports_due != 0) $display("%0d press reports never arrived", reports_due);
    if (mismatches == 0 && reports_due == 0) begin
      $display("tb_debounced_multi_press_counter OK");
    end else begin
      $display("tb_debounced_multi_press_counter NOT OK");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Timed out after %0d samples", samples_sent);
    $display("tb_debounced_multi_press_counter NOT OK");
    $finish;
  end

endmodule
